// ===== hdl/hufd_pkg.sv =====
// Shared types and codes for the Huffman tree-walk decoder.
// Depends on nothing; used by hufd_tree_build and huffman_tree_bit_decoder.
`timescale 1ns / 1ps
`default_nettype none

package hufd_pkg;

  // Action codes carried by an input beat.
  typedef enum logic [1:0] {
    ACT_LEAF     = 2'd0,
    ACT_INTERNAL = 2'd1,
    ACT_DATA     = 2'd2,
    ACT_CLEAR    = 2'd3
  } action_e;

  // Largest number of bits decoded from one data byte.
  localparam logic [3:0] MAX_BITS = 4'd8;

  // Input beat.
  typedef struct packed {
    logic [1:0] action;
    logic [7:0] leaf_symbol;
    logic [7:0] data_byte;
    logic [3:0] valid_bits;
  } in_beat_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } out_beat_t;

  // Commands from the sequencer to the tree builder.
  typedef struct packed {
    logic       start;
    logic       clear;
    logic       leaf;
    logic [7:0] sym;
  } tok_cmd_t;

  // Status from the tree builder.
  typedef struct packed {
    logic       busy;
    logic       complete;
    logic       root_leaf;
    logic [7:0] root_sym;
  } tree_stat_t;

endpackage

`default_nettype wire

// ===== hdl/hufd_tree_build.sv =====
// Tree builder: turns preorder tokens into child tables using a stack of open parents.
// Holds the child memories and their registered read port. Depends on hufd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hufd_tree_build
  import hufd_pkg::*;
#(
  parameter int SYMBOL_BITS = 8,
  parameter int NODE_COUNT  = 512,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tok_cmd_t                      cmd_i,
  output tree_stat_t                         stat_o,
  input  wire logic                          rd_en_i,
  input  wire logic [$clog2(NODE_COUNT)-1:0] rd_addr_i,
  input  wire logic                          rd_right_i,
  output logic                               ch_leaf_o,
  output logic [7:0]                         ch_sym_o,
  output logic [$clog2(NODE_COUNT)-1:0]      ch_idx_o
);

  localparam int IDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W = $clog2(NODE_COUNT + 1);
  localparam int SP_W  = $clog2(STACK_DEPTH);
  localparam int TOP_W = $clog2(STACK_DEPTH + 1);
  localparam int SW    = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;
  localparam int ENT_W = 1 + SW + IDX_W;
  localparam int STK_W = 1 + IDX_W;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_UPD  = 4'b0010,
    B_PUSH = 4'b0100,
    B_FIN  = 4'b1000
  } bstate_e;

  bstate_e            state_q, state_d;
  logic [TOP_W-1:0]   top_q, top_d;
  logic [CNT_W-1:0]   nodes_q, nodes_d;
  logic               complete_q, complete_d;
  logic               root_leaf_q, root_leaf_d;
  logic [SW-1:0]      root_sym_q;
  logic [IDX_W-1:0]   idx_q;
  logic               leaf_q;
  logic [SW-1:0]      sym_q;

  // Child entries hold the child's leaf flag, symbol and index.
  logic [ENT_W-1:0]   left_mem  [NODE_COUNT];
  logic [ENT_W-1:0]   right_mem [NODE_COUNT];
  logic [STK_W-1:0]   stk_mem   [STACK_DEPTH];
  logic [ENT_W-1:0]   left_rd_q, right_rd_q, ch_ent;
  logic               rd_right_q;
  logic [STK_W-1:0]   stk_rd_q;

  logic               ignore, latch;
  logic               stk_we, stk_re, left_we, right_we;
  logic [SP_W-1:0]    stk_waddr, top_m1;
  logic [STK_W-1:0]   stk_wdata;
  logic [IDX_W-1:0]   pn;
  logic               left_done;

  assign top_m1    = SP_W'(top_q - 1'b1);
  assign pn        = stk_rd_q[IDX_W-1:0];
  assign left_done = stk_rd_q[IDX_W];
  assign ignore    = complete_q || (nodes_q >= CNT_W'(NODE_COUNT)) ||
                     (!cmd_i.leaf && (top_q >= TOP_W'(STACK_DEPTH)));

  // Token sequencer: allocate, link to the open parent, push internal nodes.
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    nodes_d     = nodes_q;
    complete_d  = complete_q;
    root_leaf_d = root_leaf_q;
    latch       = 1'b0;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = top_m1;
    stk_wdata   = {1'b1, pn};
    left_we     = 1'b0;
    right_we    = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (cmd_i.clear) begin
          top_d      = '0;
          nodes_d    = '0;
          complete_d = 1'b0;
        end else if (cmd_i.start && !ignore) begin
          latch   = 1'b1;
          nodes_d = nodes_q + 1'b1;
          if (nodes_q == '0) begin
            root_leaf_d = cmd_i.leaf;
          end
          if (top_q != '0) begin
            stk_re  = 1'b1;
            state_d = B_UPD;
          end else if (!cmd_i.leaf) begin
            state_d = B_PUSH;
          end else begin
            state_d = B_FIN;
          end
        end
      end
      B_UPD: begin
        if (!left_done) begin
          left_we = 1'b1;
          stk_we  = 1'b1;
        end else begin
          right_we = 1'b1;
          top_d    = top_q - 1'b1;
        end
        state_d = leaf_q ? B_FIN : B_PUSH;
      end
      B_PUSH: begin
        stk_we    = 1'b1;
        stk_waddr = top_q[SP_W-1:0];
        stk_wdata = {1'b0, idx_q};
        top_d     = top_q + 1'b1;
        state_d   = B_FIN;
      end
      B_FIN: begin
        if (top_q == '0) begin
          complete_d = 1'b1;
        end
        state_d = B_IDLE;
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      top_q       <= '0;
      nodes_q     <= '0;
      complete_q  <= 1'b0;
      root_leaf_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      nodes_q     <= nodes_d;
      complete_q  <= complete_d;
      root_leaf_q <= root_leaf_d;
    end
  end

  // Token payload.
  always_ff @(posedge clk_i) begin
    if (latch) begin
      idx_q  <= nodes_q[IDX_W-1:0];
      leaf_q <= cmd_i.leaf;
      sym_q  <= cmd_i.sym[SW-1:0];
      if (nodes_q == '0) begin
        root_sym_q <= cmd_i.sym[SW-1:0];
      end
    end
  end

  // Stack of open parents.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[top_m1];
    end
  end

  // Child tables with a registered read for the walk.
  always_ff @(posedge clk_i) begin
    if (left_we) begin
      left_mem[pn] <= {leaf_q, sym_q, idx_q};
    end
    if (right_we) begin
      right_mem[pn] <= {leaf_q, sym_q, idx_q};
    end
    if (rd_en_i) begin
      left_rd_q  <= left_mem[rd_addr_i];
      right_rd_q <= right_mem[rd_addr_i];
      rd_right_q <= rd_right_i;
    end
  end

  assign ch_ent    = rd_right_q ? right_rd_q : left_rd_q;
  assign ch_leaf_o = ch_ent[ENT_W-1];
  assign ch_sym_o  = 8'(ch_ent[ENT_W-2:IDX_W]);
  assign ch_idx_o  = ch_ent[IDX_W-1:0];

  assign stat_o.busy      = (state_q != B_IDLE);
  assign stat_o.complete  = complete_q;
  assign stat_o.root_leaf = root_leaf_q;
  assign stat_o.root_sym  = 8'(root_sym_q);

endmodule

`default_nettype wire

// ===== hdl/huffman_tree_bit_decoder.sv =====
// Huffman tree-walk decoder: one child-table lookup per encoded bit.
// A data byte goes through a start step, one bit step per bit on the child-table read port
// and a flush; each symbol is held until the next is found and the last leaves at the flush.
// Output stalls can hold the bit steps and the flush.
// Reset clears all control state; node tables and stack are not initialized.
// Depends on hufd_pkg and hufd_tree_build.
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_bit_decoder
  import hufd_pkg::*;
#(
  parameter int SYMBOL_BITS = 8,
  parameter int NODE_COUNT  = 512,
  parameter int STACK_DEPTH = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  localparam int IDX_W = $clog2(NODE_COUNT);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_TOKEN  = 5'b00010,
    S_WSTART = 5'b00100,
    S_WBIT   = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [7:0]       shift_q, shift_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [IDX_W-1:0] walk_q, walk_d;
  logic             pend_vld_q, pend_vld_d;
  logic [7:0]       pend_sym_q, pend_sym_d;
  logic             out_vld_q, out_vld_d;
  out_beat_t        out_q, out_d;

  tok_cmd_t         cmd;
  tree_stat_t       stat;
  logic             rd_en, rd_right;
  logic [IDX_W-1:0] rd_addr;
  logic             ch_leaf;
  logic [7:0]       ch_sym;
  logic [IDX_W-1:0] ch_idx;

  logic             in_acc, out_free, hit, hold;
  logic [7:0]       hit_sym;
  action_e          act;

  hufd_tree_build #(
    .SYMBOL_BITS (SYMBOL_BITS),
    .NODE_COUNT  (NODE_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_tree (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_right_i (rd_right),
    .ch_leaf_o  (ch_leaf),
    .ch_sym_o   (ch_sym),
    .ch_idx_o   (ch_idx)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  assign act        = action_e'(in_data_i.action);

  // A single-leaf tree emits its root symbol on every bit.
  assign hit     = stat.root_leaf || ch_leaf;
  assign hit_sym = stat.root_leaf ? stat.root_sym : ch_sym;
  assign hold    = hit && pend_vld_q && !out_free;

  // Walk sequencer. The newest symbol waits in the pending slot so that the
  // final symbol of a byte can carry last.
  always_comb begin
    state_d    = state_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;
    walk_d     = walk_q;
    pend_vld_d = pend_vld_q;
    pend_sym_d = pend_sym_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_d      = out_q;
    cmd.start  = 1'b0;
    cmd.clear  = 1'b0;
    cmd.leaf   = (act == ACT_LEAF);
    cmd.sym    = in_data_i.leaf_symbol;
    rd_en      = 1'b0;
    rd_addr    = walk_q;
    rd_right   = shift_q[7];
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (act)
            ACT_LEAF, ACT_INTERNAL: begin
              cmd.start = 1'b1;
              state_d   = S_TOKEN;
            end
            ACT_CLEAR: begin
              cmd.clear = 1'b1;
              walk_d    = '0;
            end
            ACT_DATA: begin
              if (stat.complete && (in_data_i.valid_bits != 4'd0)) begin
                shift_d = in_data_i.data_byte;
                cnt_d   = (in_data_i.valid_bits > MAX_BITS) ? MAX_BITS
                                                            : in_data_i.valid_bits;
                state_d = S_WSTART;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_TOKEN: begin
        if (!stat.busy) begin
          state_d = S_IDLE;
        end
      end
      S_WSTART: begin
        rd_en   = 1'b1;
        state_d = S_WBIT;
      end
      S_WBIT: begin
        if (!hold) begin
          if (hit) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_d     = '{symbol: pend_sym_q, last: 1'b0};
            end
            pend_vld_d = 1'b1;
            pend_sym_d = hit_sym;
            walk_d     = '0;
          end else begin
            walk_d = ch_idx;
          end
          shift_d = {shift_q[6:0], 1'b0};
          cnt_d   = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            state_d = S_FLUSH;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = walk_d;
            rd_right = shift_q[6];
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_vld_d  = 1'b1;
          out_d      = '{symbol: pend_sym_q, last: 1'b1};
          pend_vld_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      walk_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      walk_q     <= walk_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    pend_sym_q <= pend_sym_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // A bit step always has bits left to decode.
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WBIT) |-> (cnt_q != 4'd0))
    else $error("bit step with no bits left");

  // No symbol is left pending between items.
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_vld_q)
    else $error("pending symbol while idle");

  // A single-leaf tree never moves off the root.
  a_root_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.complete && stat.root_leaf) |-> (walk_q == '0))
    else $error("walk left the root of a single-leaf tree");

  // New beats are only taken when the builder is idle.
  a_build_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !stat.busy)
    else $error("input taken while the tree builder is busy");
`endif

endmodule

`default_nettype wire

// ===== tb/hufd_symbol_check.sv =====
// Watches both channels of the Huffman tree-walk decoder, keeps its own copy of the
// code tree and walk state, and compares every output beat with the predicted symbol.
// Depends on hufd_pkg for the beat types and action codes.
`timescale 1ns / 1ps

module hufd_symbol_check
  import hufd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int NODES   = 512;
  localparam int PARENTS = 256;

  // Code tree as built from the token stream.
  logic       node_is_leaf [NODES];
  logic [7:0] node_sym     [NODES];
  logic [8:0] child_zero   [NODES];
  logic [8:0] child_one    [NODES];

  // Internal nodes that still wait for a child.
  logic [8:0] open_node    [PARENTS];
  logic       open_has_left[PARENTS];

  logic [8:0] open_depth;
  logic [9:0] node_fill;
  logic       tree_ready;
  logic [8:0] cursor;

  out_beat_t  expected_symbols[$];
  int         mismatches;

  // Scratch for decoding one data beat and checking one output beat.
  int         bit_count;
  logic [8:0] next_node;
  out_beat_t  found[8];
  int         n_found;
  out_beat_t  want;

  task automatic wipe_tree();
    open_depth = '0;
    node_fill  = '0;
    tree_ready = 1'b0;
    cursor     = '0;
  endtask

  // Adds one preorder token to the tree and hooks it under the innermost open parent.
  task automatic add_node(input logic leaf, input logic [7:0] sym);
    logic [8:0] idx;
    logic [8:0] parent;
    if (tree_ready || node_fill >= NODES) return;
    if (!leaf && open_depth >= PARENTS) return;
    idx = node_fill[8:0];
    node_fill = node_fill + 10'd1;
    node_is_leaf[idx] = leaf;
    node_sym[idx]     = sym;
    child_zero[idx]   = '0;
    child_one[idx]    = '0;
    if (idx != 0 && open_depth != 0) begin
      parent = open_node[open_depth - 1];
      if (!open_has_left[open_depth - 1]) begin
        child_zero[parent] = idx;
        open_has_left[open_depth - 1] = 1'b1;
      end else begin
        child_one[parent] = idx;
        open_depth = open_depth - 9'd1;
      end
    end
    if (!leaf) begin
      open_node[open_depth]     = idx;
      open_has_left[open_depth] = 1'b0;
      open_depth = open_depth + 9'd1;
    end
    if (open_depth == 0) begin
      tree_ready = 1'b1;
      cursor     = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wipe_tree();
      expected_symbols.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Predict from the accepted input beat first, so a result can never overtake it.
      if (in_valid_i && !in_stall_i) begin
        case (in_data_i.action)
          ACT_LEAF:     add_node(1'b1, in_data_i.leaf_symbol);
          ACT_INTERNAL: add_node(1'b0, in_data_i.leaf_symbol);
          ACT_DATA: begin
            n_found = 0;
            if (tree_ready) begin
              bit_count = int'((in_data_i.valid_bits > MAX_BITS) ? MAX_BITS
                                                                 : in_data_i.valid_bits);
              for (int i = 0; i < bit_count; i++) begin
                if (node_is_leaf[0]) begin
                  // A lone root leaf stands for every single bit.
                  found[n_found].symbol = node_sym[0];
                  found[n_found].last   = 1'b0;
                  n_found++;
                end else begin
                  next_node = in_data_i.data_byte[7 - i] ? child_one[cursor] : child_zero[cursor];
                  if (!node_is_leaf[next_node]) begin
                    cursor = next_node;
                  end else begin
                    found[n_found].symbol = node_sym[next_node];
                    found[n_found].last   = 1'b0;
                    n_found++;
                    cursor = '0;
                  end
                end
              end
            end
            // An unfinished code keeps the cursor and adds no symbol for its bits.
            if (n_found > 0) found[n_found - 1].last = 1'b1;
            for (int k = 0; k < n_found; k++) expected_symbols.push_back(found[k]);
          end
          default: wipe_tree();
        endcase
      end

      // Compare an accepted output beat with the oldest expected symbol.
      if (out_valid_i && !out_stall_i) begin
        if (expected_symbols.size() == 0) begin
          $error("unexpected output beat: symbol %0h last %0b",
                 out_data_i.symbol, out_data_i.last);
          mismatches++;
        end else begin
          want = expected_symbols.pop_front();
          if (out_data_i.symbol !== want.symbol) begin
            $error("symbol: expected %0h, got %0h", want.symbol, out_data_i.symbol);
            mismatches++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data_i.last);
            mismatches++;
          end
        end
      end

      fail_count_o <= mismatches;
      pending_o    <= expected_symbols.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the Huffman decoder testbench: clock, reset, stimulus and the final verdict.
// Depends on hufd_pkg, huffman_tree_bit_decoder and the hufd_symbol_check monitor.
`timescale 1ns / 1ps

module testbench;
  import hufd_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_beat;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_beat;

  int        fail_count;
  int        pending;
  int        beats_sent = 0;
  int        gap_max = 19;
  bit        long_hold_req = 1'b0;

  huffman_tree_bit_decoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat)
  );

  hufd_symbol_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_beat),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_beat),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one beat after a random gap and holds it until it is taken.
  // Starts and ends at a falling edge.
  task automatic send_beat(input in_beat_t beat);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= beat;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    beats_sent++;
  endtask

  // Tree tokens and clears; the fields they do not use carry random bits.
  task automatic send_token(input action_e act, input logic [7:0] sym);
    in_beat_t beat;
    beat.action      = act;
    beat.leaf_symbol = sym;
    beat.data_byte   = 8'($urandom);
    beat.valid_bits  = 4'($urandom);
    send_beat(beat);
  endtask

  task automatic send_data(input logic [7:0] bits, input logic [3:0] n_bits);
    in_beat_t beat;
    beat.action      = ACT_DATA;
    beat.leaf_symbol = 8'($urandom);
    beat.data_byte   = bits;
    beat.valid_bits  = n_bits;
    send_beat(beat);
  endtask

  // Sends a random preorder tree with the given number of leaves. When cut_short
  // is set, the stream stops early and leaves the tree open.
  task automatic build_tree(input int leaves, input bit cut_short);
    int  inner;
    int  open_slots;
    int  done;
    int  stop_at;
    bit  pick_leaf;
    inner      = leaves - 1;
    open_slots = 1;
    done       = 0;
    stop_at    = cut_short ? $urandom_range(0, 2 * leaves - 2) : 2 * leaves;
    while (open_slots > 0 && done < stop_at) begin
      if (inner == 0) pick_leaf = 1'b1;
      else if (open_slots == 1) pick_leaf = 1'b0;
      else pick_leaf = 1'($urandom_range(0, 1));
      if (pick_leaf) begin
        send_token(ACT_LEAF, 8'($urandom));
        open_slots--;
      end else begin
        send_token(ACT_INTERNAL, 8'($urandom));
        inner--;
        open_slots++;
      end
      done++;
    end
  endtask

  // Output side: a random hold before each beat, with calm bursts and one long hold.
  initial begin
    int wait_n;
    int burst;
    int stall_max;
    burst     = 0;
    stall_max = 19;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (burst == 0) begin
        burst     = 16;
        stall_max = ($urandom_range(0, 2) == 0) ? 0 : 19;
      end
      burst--;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        wait_n = 400;
      end else begin
        wait_n = $urandom_range(0, stall_max);
      end
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    in_beat_t   noise;
    int         start;
    logic [3:0] n_bits;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Data before any tree is dropped.
    send_data(8'hFF, MAX_BITS);

    // A one-leaf tree gives its symbol once per bit; zero bits give nothing,
    // and a count above eight is taken as eight.
    send_token(ACT_LEAF, 8'hFF);
    send_data(8'hA5, MAX_BITS);
    send_data(8'h3C, 4'd0);
    send_data(8'h5A, 4'd15);

    // Tokens after a complete tree are ignored.
    send_token(ACT_LEAF, 8'h00);
    send_token(ACT_INTERNAL, 8'h11);
    send_data(8'h80, 4'd1);

    // Three-symbol tree: 0 -> 00, 10 -> 80, 11 -> 7F. A code left unfinished at
    // the end of one beat carries on into the next.
    send_token(ACT_CLEAR, 8'h00);
    send_token(ACT_INTERNAL, 8'hFF);
    send_token(ACT_LEAF, 8'h00);
    send_token(ACT_INTERNAL, 8'h00);
    send_token(ACT_LEAF, 8'h80);
    send_token(ACT_LEAF, 8'h7F);
    send_data(8'b1011_0000, 4'd3);
    send_data(8'b1000_0000, 4'd2);
    send_data(8'h00, MAX_BITS);
    send_data(8'hFF, MAX_BITS);
    send_token(ACT_CLEAR, 8'hFF);

    // Long output hold while input beats keep coming back to back.
    gap_max = 0;
    long_hold_req = 1'b1;
    build_tree(12, 1'b0);
    repeat (24) send_data(8'($urandom), MAX_BITS);

    // Random part: mostly clear, full tree and data; some cut trees and raw noise.
    start = beats_sent;
    while (beats_sent - start < 165) begin
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          noise = in_beat_t'($urandom);
          send_beat(noise);
        end
      end else begin
        send_token(ACT_CLEAR, 8'($urandom));
        build_tree($urandom_range(1, 16), $urandom_range(0, 7) == 0);
        repeat ($urandom_range(1, 8)) begin
          n_bits = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 8));
          send_data(8'($urandom), n_bits);
        end
      end
    end
    in_valid <= 1'b0;

    // Drain, then keep watching for stray output before the verdict.
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
